// ----- src/ccts_pkg.sv -----
// Package for the cycle counter timebase: widths, constants and the structs
// passed between the front, the queue, the back end and the divider.
// Depends on nothing.
`timescale 1ns / 1ps

package ccts_pkg;

  localparam int CNT_W   = 32;  // width of one counter sample
  localparam int EXT_W   = 64;  // width of the extended count
  localparam int CPU_W   = 10;  // width of the cycles-per-microsecond register
  localparam int DSR_W   = 30;  // divisor width, holds cycles_per_us times 1000000
  localparam int WIN_W   = 20;  // width of the microseconds within one second
  localparam int RECIP_W = 21;  // width of the reciprocal of 1000
  localparam int ITER_W  = 7;   // iteration counter, holds up to 64
  localparam int PART_W  = 10;  // width of the millisecond and microsecond parts
  localparam int CFG_AW  = 3;   // configuration address width
  localparam int CFG_DW  = 32;  // configuration data width

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [CPU_W-1:0] CPU_RESET = 10'd480;
  localparam logic [DSR_W-1:0] US_PER_SEC = 30'd1000000;
  localparam logic [PART_W-1:0] US_PER_MS = 10'd1000;

  // 2^30 / 1000 rounded up; the product shifted right by 30 gives the exact
  // quotient by 1000 for every value below 2^20.
  localparam logic [RECIP_W-1:0] MS_RECIP = 21'd1073742;
  localparam int MS_SHIFT = 30;

  // Iteration counts of the divider for the three divisions.
  localparam logic [ITER_W-1:0] ITERS_FULL = 7'd64;
  localparam logic [ITER_W-1:0] ITERS_REM  = 7'd30;

  // Register index of cycles_per_us.
  localparam logic [0:0] REG_CYCLES_PER_US = 1'b0;

  typedef struct packed {
    logic             start;
    logic [EXT_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
    logic [ITER_W-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [EXT_W-1:0] quotient;
    logic [DSR_W-1:0] remainder;
  } div_rsp_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- src/ccts_front.sv -----
// Front end of the timebase: takes counter samples, detects wraps and forms
// the 64-bit extended count that it pushes into the queue.
// Depends on ccts_pkg.
`timescale 1ns / 1ps

module ccts_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic [ccts_pkg::CNT_W-1:0]    sample,
  input  ccts_pkg::q_stat_t             q_stat,
  output logic                          q_push,
  output logic [ccts_pkg::EXT_W-1:0]    q_data
);

  logic [ccts_pkg::CNT_W-1:0] wrap_r, wrap_nxt;
  logic [ccts_pkg::CNT_W-1:0] prev_r, prev_nxt;

  assign q_push = push && !q_stat.full;

  always_comb begin
    wrap_nxt = wrap_r;
    prev_nxt = prev_r;
    if (q_push) begin
      // A sample strictly below the last one means the counter wrapped.
      if (sample < prev_r) begin
        wrap_nxt = wrap_r + 1'b1;
      end
      prev_nxt = sample;
    end
  end

  assign q_data = {wrap_nxt, sample};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_r <= '0;
      prev_r <= '0;
    end else begin
      wrap_r <= wrap_nxt;
      prev_r <= prev_nxt;
    end
  end

endmodule

// ----- src/ccts_fifo.sv -----
// Short queue of extended counts between the front and the back end.
// Depends on ccts_pkg.
`timescale 1ns / 1ps

module ccts_fifo #(
  parameter int QUEUE_DEPTH = ccts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [ccts_pkg::EXT_W-1:0] wr_data,
  input  logic                       rd_en,
  output logic [ccts_pkg::EXT_W-1:0] rd_data,
  output ccts_pkg::q_stat_t          stat
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  logic [ccts_pkg::EXT_W-1:0] mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic do_wr, do_rd;

  assign stat.full  = (count_r == FULL_CNT);
  assign stat.empty = (count_r == '0);
  assign do_wr = wr_en && !stat.full;
  assign do_rd = rd_en && !stat.empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- src/ccts_div.sv -----
// Restoring divider, one quotient bit per cycle, with a run length chosen per
// request. The dividend is consumed from its top bit down.
// Depends on ccts_pkg.
`timescale 1ns / 1ps

module ccts_div (
  input  logic               clk,
  input  logic               rst_n,
  input  ccts_pkg::div_req_t req,
  output ccts_pkg::div_rsp_t rsp
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [ccts_pkg::ITER_W-1:0] cnt_r, cnt_nxt;
  logic [ccts_pkg::EXT_W-1:0]  quo_r, quo_nxt;
  logic [ccts_pkg::DSR_W-1:0]  rem_r, rem_nxt;
  logic [ccts_pkg::DSR_W-1:0]  dsr_r, dsr_nxt;
  logic [ccts_pkg::DSR_W:0]    trial;
  logic [ccts_pkg::DSR_W:0]    diff;
  logic                        fits;

  assign trial = {rem_r, quo_r[ccts_pkg::EXT_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign fits  = (trial >= {1'b0, dsr_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (busy_r) begin
      quo_nxt = {quo_r[ccts_pkg::EXT_W-2:0], fits};
      rem_nxt = fits ? diff[ccts_pkg::DSR_W-1:0] : trial[ccts_pkg::DSR_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == ccts_pkg::ITER_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.iters;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

// ----- src/ccts_back.sv -----
// Back end of the timebase: pops extended counts, runs the three divisions on
// the shared divider, splits the leftover microseconds by a reciprocal multiply
// and holds the finished result in the output register. Depends on ccts_pkg.
`timescale 1ns / 1ps

module ccts_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ccts_pkg::CPU_W-1:0]    cycles_per_us,
  input  ccts_pkg::q_stat_t             q_stat,
  input  logic [ccts_pkg::EXT_W-1:0]    q_data,
  output logic                          q_pop,
  output ccts_pkg::div_req_t            div_req,
  input  ccts_pkg::div_rsp_t            div_rsp,
  input  logic                          pop,
  output logic                          out_valid,
  output logic [ccts_pkg::EXT_W-1:0]    ext_o,
  output logic [ccts_pkg::EXT_W-1:0]    total_o,
  output logic [ccts_pkg::CNT_W-1:0]    sec_o,
  output logic [ccts_pkg::PART_W-1:0]   ms_o,
  output logic [ccts_pkg::PART_W-1:0]   us_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_US    = 3'd1;
  localparam logic [2:0] ST_SEC   = 3'd2;
  localparam logic [2:0] ST_MS    = 3'd3;
  localparam logic [2:0] ST_SPLIT = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam int PAD_W = ccts_pkg::EXT_W - ccts_pkg::DSR_W;
  localparam int PROD_W = ccts_pkg::WIN_W + ccts_pkg::RECIP_W;

  logic [2:0] state_r, state_nxt;
  logic       vld_r, vld_nxt;
  logic       load;

  logic [ccts_pkg::EXT_W-1:0]  ext_r, ext_nxt;
  logic [ccts_pkg::EXT_W-1:0]  total_r, total_nxt;
  logic [ccts_pkg::CNT_W-1:0]  sec_r, sec_nxt;
  logic [ccts_pkg::WIN_W-1:0]  win_r, win_nxt;
  logic [ccts_pkg::PART_W-1:0] ms_r, ms_nxt;
  logic [ccts_pkg::PART_W-1:0] us_r, us_nxt;

  logic [ccts_pkg::EXT_W-1:0]  oext_r, ototal_r;
  logic [ccts_pkg::CNT_W-1:0]  osec_r;
  logic [ccts_pkg::PART_W-1:0] oms_r, ous_r;

  logic [ccts_pkg::DSR_W-1:0] cpu_div;
  logic [ccts_pkg::DSR_W-1:0] sec_div;
  logic [PROD_W-1:0]          ms_prod;
  logic [ccts_pkg::WIN_W-1:0] ms_scaled;
  logic [ccts_pkg::WIN_W-1:0] us_full;

  // A zero divisor is taken as one.
  assign cpu_div = (cycles_per_us == '0) ? ccts_pkg::DSR_W'(1)
                                         : ccts_pkg::DSR_W'(cycles_per_us);

  // Whole seconds come straight from the extended count: dividing by
  // cycles_per_us and then by one million truncates the same way as one
  // division by their product, and the remainder holds the cycles left
  // within the second.
  assign sec_div = cpu_div * ccts_pkg::US_PER_SEC;

  // Milliseconds within the second by reciprocal multiply, then the
  // microseconds as what is left over.
  assign ms_prod = {{ccts_pkg::RECIP_W{1'b0}}, div_rsp.quotient[ccts_pkg::WIN_W-1:0]}
                 * {{ccts_pkg::WIN_W{1'b0}}, ccts_pkg::MS_RECIP};
  assign ms_scaled = {{(ccts_pkg::WIN_W-ccts_pkg::PART_W){1'b0}}, ms_r}
                   * {{(ccts_pkg::WIN_W-ccts_pkg::PART_W){1'b0}}, ccts_pkg::US_PER_MS};
  assign us_full = win_r - ms_scaled;

  assign load = (state_r == ST_DONE) && (!vld_r || pop);

  always_comb begin
    state_nxt = state_r;
    ext_nxt   = ext_r;
    total_nxt = total_r;
    sec_nxt   = sec_r;
    win_nxt   = win_r;
    ms_nxt    = ms_r;
    us_nxt    = us_r;
    q_pop     = 1'b0;
    div_req   = '0;
    case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          q_pop            = 1'b1;
          ext_nxt          = q_data;
          div_req.start    = 1'b1;
          div_req.dividend = q_data;
          div_req.divisor  = cpu_div;
          div_req.iters    = ccts_pkg::ITERS_FULL;
          state_nxt        = ST_US;
        end
      end
      ST_US: begin
        if (div_rsp.done) begin
          total_nxt        = div_rsp.quotient;
          div_req.start    = 1'b1;
          div_req.dividend = ext_r;
          div_req.divisor  = sec_div;
          div_req.iters    = ccts_pkg::ITERS_FULL;
          state_nxt        = ST_SEC;
        end
      end
      ST_SEC: begin
        if (div_rsp.done) begin
          sec_nxt          = div_rsp.quotient[ccts_pkg::CNT_W-1:0];
          // The cycles left within the second go in at the top of the
          // dividend, so thirty steps turn them into microseconds.
          div_req.start    = 1'b1;
          div_req.dividend = {div_rsp.remainder, {PAD_W{1'b0}}};
          div_req.divisor  = cpu_div;
          div_req.iters    = ccts_pkg::ITERS_REM;
          state_nxt        = ST_MS;
        end
      end
      ST_MS: begin
        if (div_rsp.done) begin
          win_nxt   = div_rsp.quotient[ccts_pkg::WIN_W-1:0];
          ms_nxt    = ms_prod[ccts_pkg::MS_SHIFT +: ccts_pkg::PART_W];
          state_nxt = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        us_nxt    = us_full[ccts_pkg::PART_W-1:0];
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    vld_nxt = vld_r;
    if (pop && vld_r) begin
      vld_nxt = 1'b0;
    end
    if (load) begin
      vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ext_r   <= ext_nxt;
    total_r <= total_nxt;
    sec_r   <= sec_nxt;
    win_r   <= win_nxt;
    ms_r    <= ms_nxt;
    us_r    <= us_nxt;
    if (load) begin
      oext_r   <= ext_r;
      ototal_r <= total_r;
      osec_r   <= sec_r;
      oms_r    <= ms_r;
      ous_r    <= us_r;
    end
  end

  assign out_valid = vld_r;
  assign ext_o     = oext_r;
  assign total_o   = ototal_r;
  assign sec_o     = osec_r;
  assign ms_o      = oms_r;
  assign us_o      = ous_r;

endmodule

// ----- src/cycle_count_timebase.sv -----
// Top level of the cycle counter timebase: configuration register, front end,
// queue, back end and shared divider. Depends on ccts_pkg and the ccts_ design modules.
`timescale 1ns / 1ps

// Channel        Handshake             Payload
// input          push / full           in_counter_sample (32)
// result         empty / pop           out_extended_count (64), out_total_microseconds (64),
//                                      out_seconds_part (32), out_millis_part (10),
//                                      out_micros_part (10)
// configuration  psel/penable/pwrite   paddr (3), pwdata/prdata (32), pready
//
// The front end takes a sample in the cycle it is requested when the queue is
// not full and updates the wrap count at once; the request then waits in a
// short queue. The back end takes one request at a time through the shared
// bit-per-cycle divider: 64 steps for cycles to microseconds, 64 steps that divide
// the extended count by cycles_per_us times one million for whole seconds, and
// 30 steps that turn the cycles left within the second into microseconds; a
// reciprocal multiply then splits off the milliseconds, and the rest gives the microseconds.
// Reset is synchronous and active low; it clears the wrap count, the last
// sample, the queue and the result valid flag and loads cycles_per_us = 480.
// A result not popped keeps the back end in its final state while the front
// end still fills the queue; full rises once the queue holds its depth.

module cycle_count_timebase #(
  parameter int QUEUE_DEPTH = ccts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input channel.
  input  logic                          push,
  output logic                          full,
  input  logic [ccts_pkg::CNT_W-1:0]    in_counter_sample,
  // Result channel.
  output logic                          empty,
  input  logic                          pop,
  output logic [ccts_pkg::EXT_W-1:0]    out_extended_count,
  output logic [ccts_pkg::EXT_W-1:0]    out_total_microseconds,
  output logic [ccts_pkg::CNT_W-1:0]    out_seconds_part,
  output logic [ccts_pkg::PART_W-1:0]   out_millis_part,
  output logic [ccts_pkg::PART_W-1:0]   out_micros_part,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ccts_pkg::CFG_AW-1:0]   paddr,
  input  logic [ccts_pkg::CFG_DW-1:0]   pwdata,
  output logic [ccts_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  logic [ccts_pkg::CPU_W-1:0] cpu_r, cpu_nxt;
  logic                       reg_sel;
  logic                       wr_cpu;

  ccts_pkg::q_stat_t          q_stat;
  ccts_pkg::div_req_t         div_req;
  ccts_pkg::div_rsp_t         div_rsp;
  logic                       q_push;
  logic                       q_pop;
  logic [ccts_pkg::EXT_W-1:0] q_wdata;
  logic [ccts_pkg::EXT_W-1:0] q_rdata;
  logic                       out_valid;

  // The register file has one entry; bit 2 of the address is the register
  // index, so a write at byte address 4 or above falls outside it and is
  // dropped. Only the low ten bits of a write are kept.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[ccts_pkg::CFG_AW-1:2] == ccts_pkg::REG_CYCLES_PER_US);
  assign wr_cpu  = psel && penable && pwrite && pready && reg_sel;
  assign cpu_nxt = wr_cpu ? pwdata[ccts_pkg::CPU_W-1:0] : cpu_r;
  assign prdata  = reg_sel ? ccts_pkg::CFG_DW'(cpu_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpu_r <= ccts_pkg::CPU_RESET;
    end else begin
      cpu_r <= cpu_nxt;
    end
  end

  ccts_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .sample (in_counter_sample),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  ccts_fifo #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .stat    (q_stat)
  );

  ccts_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cycles_per_us (cpu_r),
    .q_stat        (q_stat),
    .q_data        (q_rdata),
    .q_pop         (q_pop),
    .div_req       (div_req),
    .div_rsp       (div_rsp),
    .pop           (pop),
    .out_valid     (out_valid),
    .ext_o         (out_extended_count),
    .total_o       (out_total_microseconds),
    .sec_o         (out_seconds_part),
    .ms_o          (out_millis_part),
    .us_o          (out_micros_part)
  );

  ccts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign full  = q_stat.full;
  assign empty = !out_valid;

endmodule

// ----- src/ccts_checker.sv -----
// Port-level checks for the cycle counter timebase, bound to the top level.
// Depends on ccts_pkg and cycle_count_timebase.
`timescale 1ns / 1ps

module ccts_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          empty,
  input logic                          pop,
  input logic                          pready,
  input logic [ccts_pkg::EXT_W-1:0]    out_extended_count,
  input logic [ccts_pkg::EXT_W-1:0]    out_total_microseconds,
  input logic [ccts_pkg::PART_W-1:0]   out_millis_part,
  input logic [ccts_pkg::PART_W-1:0]   out_micros_part
);

  // A waiting result stays put until it is popped.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_extended_count)
                          && $stable(out_total_microseconds)))
    else $error("result changed while waiting");

  a_ms_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_millis_part < ccts_pkg::PART_W'(1000)))
    else $error("millisecond part out of range");

  a_us_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_micros_part < ccts_pkg::PART_W'(1000)))
    else $error("microsecond part out of range");

  a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_total_microseconds <= out_extended_count))
    else $error("quotient above dividend");

  a_ready: assert property (@(posedge clk) pready)
    else $error("pready dropped");

endmodule

bind cycle_count_timebase ccts_checker u_ccts_checker (.*);
